### sv/pled_pkg.sv
// Shared constants and command codes for the pixel LED bit encoder.
package pled_pkg;

    localparam int PIXELS         = 64;
    localparam int PIX_W          = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int IDLE_SLOTS     = 3;
    localparam int BITS_PER_PIXEL = 24;
    localparam int DATA_END       = IDLE_SLOTS + BITS_PER_PIXEL * PIXELS;
    localparam int FRAME_SLOTS    = DATA_END + 1;
    localparam int SLOT_W         = $clog2(FRAME_SLOTS);
    localparam int BIT_W          = $clog2(BITS_PER_PIXEL);
    localparam int BYTE_W         = 8;
    localparam int RGB_W          = 3 * BYTE_W;
    localparam int DUTY_W         = 10;
    localparam int CMD_W          = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int IN_TDATA_W     = 4 * BYTE_W;
    localparam int OUT_TDATA_W    = 16;

    localparam logic [DUTY_W-1:0] ONE_DUTY_RST  = 10'd68;
    localparam logic [DUTY_W-1:0] ZERO_DUTY_RST = 10'd30;

    localparam logic [CMD_W-1:0] CMD_WRITE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ONE_DUTY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_DUTY = 2'd1;

endpackage

### sv/pixel_led_bit_encoder_top.sv
// Pixel LED bit encoder: pixel store and PWM duty slot generator.
//
// Input stream (s_axis): tuser carries the command. A write stores green, red
// and blue for one pixel (ignored past the strip length), a restart rewinds
// the frame position, a next pulls one duty slot of the frame.
// Output stream (m_axis): one transfer per next command, duty in tdata and
// tlast on the trailing slot of the frame.
// Config channel: index 0 sets the one-bit duty, index 1 the zero-bit duty;
// other indexes are taken and dropped. Always ready.
// Frame: three zero slots, 24 slots per pixel from the last pixel to the
// first (green, red, blue, MSB first), one trailing zero slot.
// Path of a next: the state moves to ST_READ with the registered read of the
// pixel memory, then the result goes to the output register and m_axis.
// s_axis is not ready in ST_READ, so a next holds off any other command.
// Reset: all pixels read as zero (per-entry valid bits), frame position at
// the first slot, duties 68 and 30.
// Stall: one result waits in the output register; a next that finds it
// still full holds its read data and blocks s_axis until the slot frees.
module pixel_led_bit_encoder_top
    import pled_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pixel_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [CMD_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // duty[9:0], zero fill [15:10]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DUTY_W-1:0]      i_cfg_data
);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    t_state              r_state;
    logic [SLOT_W-1:0]   r_slot;
    logic [PIX_W-1:0]    r_pix;
    logic [BIT_W-1:0]    r_bit;
    logic [PIXELS-1:0]   r_valid;
    logic [DUTY_W-1:0]   r_one_duty;
    logic [DUTY_W-1:0]   r_zero_duty;
    logic                r_rd_vld;
    logic                r_is_data;
    logic                r_last;
    logic [BIT_W-1:0]    r_bitn;
    logic                r_out_valid;
    logic [DUTY_W-1:0]   r_out_duty;
    logic                r_out_last;

    logic                w_s_acc;
    logic                w_m_acc;
    logic [CMD_W-1:0]    w_cmd;
    logic [BYTE_W-1:0]   w_idx;
    logic [BYTE_W-1:0]   w_red;
    logic [BYTE_W-1:0]   w_green;
    logic [BYTE_W-1:0]   w_blue;
    logic                w_idx_ok;
    logic                w_we;
    logic                w_re;
    logic [RGB_W-1:0]    w_rdata;
    logic [RGB_W-1:0]    w_word;
    logic                w_bit;
    logic [DUTY_W-1:0]   w_duty;
    logic                w_slot_data;
    logic                w_slot_last;
    logic                w_out_free;

    assign w_cmd   = s_axis_tuser;
    assign w_idx   = s_axis_tdata[BYTE_W-1:0];
    assign w_red   = s_axis_tdata[2*BYTE_W-1:BYTE_W];
    assign w_green = s_axis_tdata[3*BYTE_W-1:2*BYTE_W];
    assign w_blue  = s_axis_tdata[4*BYTE_W-1:3*BYTE_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_m_acc       = r_out_valid && m_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign w_idx_ok = ({1'b0, w_idx} < (BYTE_W + 1)'(PIXELS));
    assign w_we     = w_s_acc && (w_cmd == CMD_WRITE) && w_idx_ok;
    assign w_re     = w_s_acc && (w_cmd == CMD_NEXT);

    assign w_slot_data = (r_slot >= SLOT_W'(IDLE_SLOTS)) && (r_slot < SLOT_W'(DATA_END));
    assign w_slot_last = (r_slot == SLOT_W'(FRAME_SLOTS - 1));

    pled_ram #(
        .WIDTH (RGB_W),
        .DEPTH (PIXELS)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_idx[PIX_W-1:0]),
        .i_wdata ({w_green, w_red, w_blue}),
        .i_re    (w_re),
        .i_raddr (r_pix),
        .o_rdata (w_rdata)
    );

    assign w_word = r_rd_vld ? w_rdata : '0;
    assign w_bit  = w_word[BIT_W'(RGB_W - 1) - r_bitn];
    assign w_duty = r_is_data ? (w_bit ? r_one_duty : r_zero_duty) : '0;

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_duty);
    assign m_axis_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_pix       <= PIX_W'(PIXELS - 1);
            r_bit       <= '0;
            r_valid     <= '0;
            r_one_duty  <= ONE_DUTY_RST;
            r_zero_duty <= ZERO_DUTY_RST;
            r_out_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_is_data   <= 1'b0;
            r_last      <= 1'b0;
            r_bitn      <= '0;
            r_out_duty  <= '0;
            r_out_last  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_ONE_DUTY:  r_one_duty  <= i_cfg_data;
                    REG_ZERO_DUTY: r_zero_duty <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_m_acc && (r_state != ST_READ)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_s_acc) begin
                        case (w_cmd)
                            CMD_WRITE: begin
                                if (w_idx_ok) begin
                                    r_valid[w_idx[PIX_W-1:0]] <= 1'b1;
                                end
                            end
                            CMD_RESTART: begin
                                r_slot <= '0;
                                r_pix  <= PIX_W'(PIXELS - 1);
                                r_bit  <= '0;
                            end
                            CMD_NEXT: begin
                                r_state   <= ST_READ;
                                r_rd_vld  <= r_valid[r_pix];
                                r_is_data <= w_slot_data;
                                r_last    <= w_slot_last;
                                r_bitn    <= r_bit;
                                if (w_slot_last) begin
                                    r_slot <= '0;
                                    r_pix  <= PIX_W'(PIXELS - 1);
                                    r_bit  <= '0;
                                end else begin
                                    r_slot <= r_slot + 1'b1;
                                    if (w_slot_data) begin
                                        if (r_bit == BIT_W'(BITS_PER_PIXEL - 1)) begin
                                            r_bit <= '0;
                                            r_pix <= r_pix - 1'b1;
                                        end else begin
                                            r_bit <= r_bit + 1'b1;
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_READ: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_duty  <= w_duty;
                        r_out_last  <= r_last;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_last_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == '0)
        else $error("trailing slot carries a nonzero duty");

    a_next_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc && (w_cmd == CMD_NEXT) |=> (r_state == ST_READ))
        else $error("next transfer did not start a store read");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < SLOT_W'(FRAME_SLOTS))
        else $error("frame position beyond frame length");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit < BIT_W'(BITS_PER_PIXEL))
        else $error("bit position beyond pixel width");

    a_read_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) && !w_out_free |=> (r_state == ST_READ) && $stable(w_rdata))
        else $error("pending read data lost while output stalled");
`endif

endmodule

### sv/pled_ram.sv
// Generic simple dual-port RAM with registered read data.
module pled_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
